### hdl/rfop_pkg.sv
package rfop_pkg;

  localparam int RFOP_DEPTH    = 256;
  localparam int DATA_W        = 8;
  localparam int LEN_W         = 9;
  localparam int OFS_W         = 8;
  localparam int CMD_W         = 2;
  localparam int RFOP_QLEN_RST = 256;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] data_in;
    logic [OFS_W-1:0]  offset;
  } rfop_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              overwrote;
    logic              invalid;
    logic [LEN_W-1:0]  fill_count;
  } rfop_out_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOAD
  } rfop_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;    // execute the request at this edge
    logic load_out;  // move the pending result into the output register
  } rfop_cmd_t;

endpackage

### hdl/rfop_ctrl.sv
module rfop_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rfop_pkg::rfop_cmd_t  cmd
);
  import rfop_pkg::*;

  rfop_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_LOAD: begin
        cmd.load_out = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/rfop_dp.sv
module rfop_dp #(
  parameter int DEPTH = rfop_pkg::RFOP_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rfop_pkg::rfop_cmd_t           cmd,
  input  rfop_pkg::rfop_in_t            in_data,
  input  logic                          cfg_we,
  input  logic [rfop_pkg::LEN_W-1:0]    cfg_wdata,
  output rfop_pkg::rfop_out_t           out_data
);
  import rfop_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [LEN_W-1:0] LEN_RST =
    (DEPTH < RFOP_QLEN_RST) ? LEN_W'(DEPTH) : LEN_W'(RFOP_QLEN_RST);

  // Sum of two positions below len, wrapped once at len.
  function automatic logic [LEN_W-1:0] wrap_add(input logic [LEN_W-1:0] base,
                                                input logic [LEN_W-1:0] step,
                                                input logic [LEN_W-1:0] len);
    logic [LEN_W:0] t;
    t = {1'b0, base} + {1'b0, step};
    if (t >= {1'b0, len}) t = t - {1'b0, len};
    return t[LEN_W-1:0];
  endfunction

  logic [DATA_W-1:0] ring_mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  head_r, head_nxt;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic [LEN_W-1:0]  len_wr;

  logic              pend_rd_r, pend_over_r, pend_bad_r;
  logic [LEN_W-1:0]  pend_fill_r;
  logic              rd_en, wr_en, over, bad;
  logic [LEN_W-1:0]  rd_pos, wr_pos;
  logic [LEN_W-1:0]  head_inc, head_cnt, head_ofs;
  logic              full;

  rfop_out_t         out_r;

  // Clamp the written length to 1..DEPTH.
  always_comb begin
    if (cfg_wdata == '0) len_wr = LEN_W'(1);
    else if (32'(cfg_wdata) > DEPTH) len_wr = LEN_W'(DEPTH);
    else len_wr = cfg_wdata;
  end

  assign full     = count_r >= len_r;
  assign head_inc = wrap_add(head_r, LEN_W'(1), len_r);
  assign head_cnt = wrap_add(head_r, count_r, len_r);
  assign head_ofs = wrap_add(head_r, LEN_W'(in_data.offset), len_r);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    over      = 1'b0;
    bad       = 1'b0;
    rd_pos    = head_r;
    wr_pos    = full ? head_r : head_cnt;
    case (in_data.cmd)
      CMD_INSERT: begin
        wr_en = 1'b1;
        if (full) begin
          head_nxt = head_inc;
          over     = 1'b1;
        end else begin
          count_nxt = count_r + LEN_W'(1);
        end
      end
      CMD_FETCH: begin
        if (count_r != '0) begin
          rd_en     = 1'b1;
          head_nxt  = head_inc;
          count_nxt = count_r - LEN_W'(1);
        end else begin
          bad = 1'b1;
        end
      end
      CMD_READ: begin
        rd_pos = head_ofs;
        if (LEN_W'(in_data.offset) < count_r) rd_en = 1'b1;
        else bad = 1'b1;
      end
      CMD_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
        head_nxt = head_r;
      end
    endcase
  end

  // Ring storage: at most one write or one registered read per request.
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) ring_mem[AW'(wr_pos)] <= in_data.data_in;
    if (cmd.accept && rd_en) rd_data_r <= ring_mem[AW'(rd_pos)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_RST;
      head_r  <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      len_r   <= len_wr;
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Hold the flags until the output register frees up.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_rd_r   <= rd_en;
      pend_over_r <= over;
      pend_bad_r  <= bad;
      pend_fill_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.data_out   <= pend_rd_r ? rd_data_r : '0;
      out_r.overwrote  <= pend_over_r;
      out_r.invalid    <= pend_bad_r;
      out_r.fill_count <= pend_fill_r;
    end
  end

  assign out_data = out_r;

endmodule

### hdl/ring_fifo_overwrite_peek.sv
// Results: an accepted request is registered into the pending flags and
//   the read data register, then moved into the output register once it
//   is free; a new request is taken only after that move.
// Reset: synchronous, active low; ring empty, head 0, length min(256, DEPTH).
//   Ring contents are not cleared and stay undefined until written.
module ring_fifo_overwrite_peek #(
  parameter int DEPTH = rfop_pkg::RFOP_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rfop_pkg::rfop_in_t          in_data,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output rfop_pkg::rfop_out_t         out_data,
  // length register write
  input  logic                        cfg_we,
  input  logic [rfop_pkg::LEN_W-1:0]  cfg_wdata
);
  import rfop_pkg::*;

  // Commands from the sequencer to the ring datapath: execute a request
  // (state update, memory write or read), then load the result once the
  // output register is free.
  rfop_cmd_t cmd;

  // Sequencer: idle until a request arrives, then hold in the load state
  // until the previous result has been taken.
  rfop_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Datapath: head, count and length registers, the ring memory, and the
  // output register. A length write empties the ring and keeps its contents.
  rfop_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

### tb/tb_ring_fifo_overwrite_peek.sv
module tb_ring_fifo_overwrite_peek;
  timeunit 1ns;
  timeprecision 1ps;

  import rfop_pkg::*;

  // Cycles with no handshake on either channel before the run is declared hung.
  localparam int HANG_LIMIT = 1000;
  // Cycles to let pass after the last reply before touching the length register.
  localparam int SETTLE_CYCLES = 2;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  rfop_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  rfop_out_t            out_data;
  logic                 cfg_we;
  logic [LEN_W-1:0]     cfg_wdata;

  ring_fifo_overwrite_peek dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the ring: contents, head, fill level and the raw length register.
  logic [DATA_W-1:0]    mirror_mem [RFOP_DEPTH];
  int                   mirror_head;
  int                   mirror_count;
  logic [LEN_W-1:0]     mirror_len;

  // Replies owed by the block, oldest first.
  rfop_out_t            pending_replies [$];

  int                   mismatches;
  int                   idle_cycles;
  // Enables random gaps on the request side and stalls on the reply side.
  bit                   gaps_on;

  // 20 ns clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Length actually used by the ring: clamp 0 up to 1 and anything past the
  // depth down to the depth.
  function automatic int ring_len();
    int len;
    len = int'(mirror_len);
    if (len < 1) len = 1;
    if (len > RFOP_DEPTH) len = RFOP_DEPTH;
    return len;
  endfunction

  // Advance a ring position by step, wrapping once at the active length.
  function automatic int ring_wrap(int base, int step, int len);
    int pos;
    pos = base + step;
    if (pos >= len) pos -= len;
    if (pos >= RFOP_DEPTH) pos = 0;
    return pos;
  endfunction

  // Apply one request to the mirror and return the reply it must produce.
  function automatic rfop_out_t predict_reply(rfop_in_t req);
    rfop_out_t rsp;
    int        len;
    len = ring_len();
    rsp = '0;
    case (req.cmd)
      CMD_INSERT: begin
        if (mirror_count >= len) begin
          // Full: overwrite the oldest slot and push the head past it.
          mirror_mem[mirror_head] = req.data_in;
          mirror_head             = ring_wrap(mirror_head, 1, len);
          rsp.overwrote           = 1'b1;
        end else begin
          mirror_mem[ring_wrap(mirror_head, mirror_count, len)] = req.data_in;
          mirror_count++;
        end
      end
      CMD_FETCH: begin
        if (mirror_count > 0) begin
          rsp.data_out = mirror_mem[mirror_head];
          mirror_head  = ring_wrap(mirror_head, 1, len);
          mirror_count--;
        end else begin
          rsp.invalid = 1'b1;
        end
      end
      CMD_READ: begin
        if (int'(req.offset) < mirror_count)
          rsp.data_out = mirror_mem[ring_wrap(mirror_head, int'(req.offset), len)];
        else
          rsp.invalid = 1'b1;
      end
      default: begin
        mirror_head  = 0;
        mirror_count = 0;
      end
    endcase
    rsp.fill_count = LEN_W'(mirror_count);
    return rsp;
  endfunction

  // Mostly no gap, sometimes a few cycles, rarely a long one.
  function automatic int random_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 48);
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < 100)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Present one request, hold it until the block takes it, then record the
  // reply it owes. Valid stays high afterwards so back-to-back requests
  // need no drop.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] data,
                              input logic [OFS_W-1:0] ofs);
    rfop_in_t req;
    int       gap;
    req.cmd     = cmd;
    req.data_in = data;
    req.offset  = ofs;
    gap         = random_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    pending_replies.push_back(predict_reply(req));
  endtask

  // Drop valid, wait for every owed reply, then give the block a few cycles.
  task automatic drain_ring();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_replies.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the length register while idle; the write also empties the ring.
  task automatic set_queue_length(input logic [LEN_W-1:0] value);
    drain_ring();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we       <= 1'b0;
    mirror_len   = value;
    mirror_head  = 0;
    mirror_count = 0;
  endtask

  // Reset length of 256: empty-ring errors, data and offset extremes, clear.
  task automatic test_empty_ring();
    send_request(CMD_FETCH,  8'h00, 8'h00);
    send_request(CMD_READ,   8'hFF, 8'h00);
    send_request(CMD_INSERT, 8'h00, 8'hFF);
    send_request(CMD_INSERT, 8'hFF, 8'h00);
    send_request(CMD_READ,   8'h00, 8'h00);
    send_request(CMD_READ,   8'h00, 8'h01);
    send_request(CMD_READ,   8'h00, 8'h02);
    send_request(CMD_READ,   8'h00, 8'hFF);
    send_request(CMD_FETCH,  8'h00, 8'h00);
    send_request(CMD_CLEAR,  8'hFF, 8'hFF);
    send_request(CMD_FETCH,  8'h00, 8'h00);
  endtask

  // Short rings: overwrite of the oldest entry, clamped lengths, and a length
  // write that drops whatever the ring held.
  task automatic test_short_ring_overwrite();
    set_queue_length(LEN_W'(1));
    send_request(CMD_INSERT, 8'hA5, 8'h00);
    send_request(CMD_INSERT, 8'h5A, 8'h00);
    send_request(CMD_READ,   8'h00, 8'h00);
    send_request(CMD_FETCH,  8'h00, 8'h00);
    // Zero length behaves as one entry.
    set_queue_length(LEN_W'(0));
    send_request(CMD_INSERT, 8'h01, 8'h00);
    send_request(CMD_INSERT, 8'h80, 8'h00);
    send_request(CMD_FETCH,  8'h00, 8'h00);
    set_queue_length(LEN_W'(3));
    send_request(CMD_INSERT, 8'h11, 8'h00);
    send_request(CMD_INSERT, 8'h22, 8'h00);
    send_request(CMD_INSERT, 8'h33, 8'h00);
    send_request(CMD_INSERT, 8'h44, 8'h00);
    send_request(CMD_READ,   8'h00, 8'h02);
    send_request(CMD_READ,   8'h00, 8'h03);
    // Length above the depth clamps to the depth; the write empties the ring.
    set_queue_length(LEN_W'(511));
    send_request(CMD_FETCH,  8'h00, 8'h00);
  endtask

  // One phase of random traffic at a given length. Reads mostly land inside
  // the held entries so that data paths get checked, the rest probe past it.
  task automatic run_random_phase(input logic [LEN_W-1:0] len, input int n_reqs,
                                  input int insert_pct, input int clear_pct, input bit gaps);
    int               roll;
    logic [CMD_W-1:0] cmd;
    logic [OFS_W-1:0] ofs;
    set_queue_length(len);
    gaps_on = gaps;
    for (int i = 0; i < n_reqs; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_pct)
        cmd = CMD_INSERT;
      else if (roll < insert_pct + clear_pct)
        cmd = CMD_CLEAR;
      else if (roll[0])
        cmd = CMD_FETCH;
      else
        cmd = CMD_READ;
      if (cmd == CMD_READ && mirror_count > 0 && $urandom_range(0, 3) != 0)
        ofs = OFS_W'($urandom_range(0, (mirror_count > 256 ? 256 : mirror_count) - 1));
      else
        ofs = OFS_W'($urandom_range(0, 255));
      send_request(cmd, DATA_W'($urandom_range(0, 255)), ofs);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(LEN_W'(1),   120, 50, 3, 1'b1);
    run_random_phase(LEN_W'(2),   120, 55, 3, 1'b0);
    run_random_phase(LEN_W'(5),   120, 50, 4, 1'b1);
    run_random_phase(LEN_W'(17),  150, 55, 2, 1'b1);
    run_random_phase(LEN_W'(0),    80, 50, 3, 1'b0);
    // Insert-heavy with no clears: fill the full-depth ring and wrap it.
    run_random_phase(LEN_W'(511), 400, 85, 0, 1'b1);
    run_random_phase(LEN_W'(300), 100, 45, 3, 1'b0);
    run_random_phase(LEN_W'(64),  150, 60, 2, 1'b1);
    run_random_phase(LEN_W'(256), 100, 40, 5, 1'b1);
  endtask

  // Reply side: stall out_ready in random bursts while gaps are enabled.
  initial begin : ready_driver
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && gaps_on) stall_left = random_gap();
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare every accepted reply against the oldest owed one.
  always @(posedge clk) begin : reply_checker
    rfop_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch($sformatf("reply with nothing owed: %p", out_data));
      end else begin
        want = pending_replies.pop_front();
        if (out_data.data_out !== want.data_out)
          flag_mismatch($sformatf("data_out %h, want %h", out_data.data_out, want.data_out));
        if (out_data.overwrote !== want.overwrote)
          flag_mismatch($sformatf("overwrote %b, want %b", out_data.overwrote, want.overwrote));
        if (out_data.invalid !== want.invalid)
          flag_mismatch($sformatf("invalid %b, want %b", out_data.invalid, want.invalid));
        if (out_data.fill_count !== want.fill_count)
          flag_mismatch($sformatf("fill_count %0d, want %0d",
                                  out_data.fill_count, want.fill_count));
      end
    end
  end

  // Hang detector: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    gaps_on      = 1'b0;
    mismatches   = 0;
    idle_cycles  = 0;
    mirror_head  = 0;
    mirror_count = 0;
    mirror_len   = LEN_W'(RFOP_QLEN_RST);
    foreach (mirror_mem[i]) mirror_mem[i] = '0;

    // Hold reset, then release it away from the rising edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_ring();
    gaps_on = 1'b1;
    test_short_ring_overwrite();
    test_random_traffic();
    drain_ring();

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### ring_fifo_overwrite_peek.f
hdl/rfop_pkg.sv
hdl/rfop_ctrl.sv
hdl/rfop_dp.sv
hdl/ring_fifo_overwrite_peek.sv
tb/tb_ring_fifo_overwrite_peek.sv
